/* hdl/nimt_pkg.sv */
// ----------------------------------------------------------------------------
// nimt_pkg
// types and codes shared by the neighbor id map table
// ----------------------------------------------------------------------------
package nimt_pkg;

    typedef enum logic [1:0] {
        KIND_LOOKUP    = 2'd0,
        KIND_SET       = 2'd1,
        KIND_FREE_NID  = 2'd2,
        KIND_FREE_LID  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_SOON   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd60;

endpackage

/* hdl/neighbor_id_map_table.sv */
// ----------------------------------------------------------------------------
// neighbor_id_map_table
// maps neighbor-assigned ids to local ids with a seconds stamp per entry
// ----------------------------------------------------------------------------
// Each request is a lookup, set, free by neighbor id or free by local id and
// yields one result. Entries live in one synchronous memory (local id and
// stamp in one word). After reset a clearing pass writes TABLE_DEPTH entries,
// one a cycle, before the first request is taken. Lookup, set and free by
// neighbor id pass through accept, memory read and result. Free by local id
// scans the memory one entry a cycle from the first unreserved index, as the
// memory has a single read port. Requests with reserved or out-of-range ids
// go straight to the result. A finished result sits in an output register;
// the next request is accepted meanwhile.
module neighbor_id_map_table #(
    parameter int TABLE_DEPTH  = 256,
    parameter int RESERVED_TOP = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // reuse_timeout_sec
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // neighbor_id, local_id, now_sec
    input  logic [1:0]  s_tuser,     // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // mapped_local_id, freed_index
    output logic [1:0]  m_tuser      // status
);
    import nimt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FIRST_FREE = RESERVED_TOP + 1;

    logic [31:0] mem [TABLE_DEPTH];
    logic [31:0] rd_q;
    logic        we;
    logic [AW-1:0] wa, ra;
    logic [31:0] wd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ra];
    end

    state_t      state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic        chk_reg, chk_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] nid_reg, nid_next, lid_reg, lid_next, now_reg, now_next;
    status_t     res_st_reg, res_st_next;
    logic [15:0] res_map_reg, res_map_next, res_free_reg, res_free_next;
    logic        mv_reg, mv_next;
    logic [31:0] md_reg, md_next;
    logic [1:0]  mu_reg, mu_next;

    logic        acc;
    logic [15:0] in_nid, in_lid, in_now;
    logic        nid_bad, lid_bad;
    logic [15:0] e_loc, e_stamp, age;

    assign in_nid = s_tdata[15:0];
    assign in_lid = s_tdata[31:16];
    assign in_now = s_tdata[47:32];
    assign s_tready = (state_reg == S_IDLE);
    assign acc = s_tvalid && s_tready;
    assign nid_bad = ({1'b0, in_nid} < 17'(FIRST_FREE)) ||
                     ({1'b0, in_nid} >= 17'(TABLE_DEPTH));
    assign lid_bad = ({1'b0, in_lid} < 17'(FIRST_FREE));
    assign e_loc   = rd_q[15:0];
    assign e_stamp = rd_q[31:16];
    assign age     = now_reg - e_stamp;

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        scan_next     = scan_reg;
        chk_next      = chk_reg;
        chk_idx_next  = chk_idx_reg;
        kind_next     = kind_reg;
        nid_next      = nid_reg;
        lid_next      = lid_reg;
        now_next      = now_reg;
        res_st_next   = res_st_reg;
        res_map_next  = res_map_reg;
        res_free_next = res_free_reg;
        mv_next       = mv_reg;
        md_next       = md_reg;
        mu_next       = mu_reg;
        we = 1'b0;
        wa = nid_reg[AW-1:0];
        wd = 32'd0;
        ra = in_nid[AW-1:0];

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    kind_next     = kind_t'(s_tuser);
                    nid_next      = in_nid;
                    lid_next      = in_lid;
                    now_next      = in_now;
                    res_map_next  = 16'd0;
                    res_free_next = 16'd0;
                    res_st_next   = ST_OK;
                    scan_next     = AW'(FIRST_FREE);
                    chk_next      = 1'b0;
                    case (kind_t'(s_tuser))
                        KIND_LOOKUP, KIND_FREE_NID:
                        begin
                            if (nid_bad)
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        KIND_SET:
                        begin
                            if (nid_bad || lid_bad)
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            if (lid_bad)
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                wa = nid_reg[AW-1:0];
                case (kind_reg)
                    KIND_LOOKUP:
                    begin
                        if (e_loc != 16'd0 && age <= timeout_reg)
                        begin
                            we = 1'b1;
                            wd = {now_reg, e_loc};
                            res_map_next = e_loc;
                        end
                        else
                        begin
                            res_st_next = ST_MISS;
                        end
                    end
                    KIND_SET:
                    begin
                        if (e_loc == 16'd0 || e_loc == lid_reg || age >= timeout_reg)
                        begin
                            we = 1'b1;
                            wd = {now_reg, lid_reg};
                        end
                        else
                        begin
                            res_st_next = ST_SOON;
                        end
                    end
                    default:
                    begin
                        if (e_loc == 16'd0)
                        begin
                            res_st_next = ST_MISS;
                        end
                        else
                        begin
                            we = 1'b1;
                            res_free_next = nid_reg;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                ra = scan_reg;
                if (chk_reg && e_loc == lid_reg)
                begin
                    we = 1'b1;
                    wa = chk_idx_reg;
                    res_free_next = 16'(chk_idx_reg);
                    state_next = S_DONE;
                end
                else if (chk_reg && chk_idx_reg == AW'(TABLE_DEPTH - 1))
                begin
                    res_st_next = ST_MISS;
                    state_next  = S_DONE;
                end
                else
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = scan_reg;
                    scan_next    = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {res_free_reg, res_map_reg};
                    mu_next    = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            mv_reg      <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            chk_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            chk_reg   <= chk_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        chk_idx_reg  <= chk_idx_next;
        kind_reg     <= kind_next;
        nid_reg      <= nid_next;
        lid_reg      <= lid_next;
        now_reg      <= now_next;
        res_st_reg   <= res_st_next;
        res_map_reg  <= res_map_next;
        res_free_reg <= res_free_next;
        md_reg       <= md_next;
        mu_reg       <= mu_next;
    end

endmodule
